// ===== design/rvc_pkg.sv =====
`default_nettype none
package rvc_pkg;

   localparam int RAM_BYTES = 1048576;
   localparam int FB_WIDTH  = 320;
   localparam int FB_HEIGHT = 200;

   localparam int FB_WORDS  = FB_WIDTH * FB_HEIGHT;
   localparam logic [31:0] FB_LIMIT = 32'(FB_WORDS * 4);
   localparam logic [31:0] FB_BASE  = 32'h2000_0000;

   localparam int RAM_ROWS  = RAM_BYTES / 4;
   localparam int ROW_W     = $clog2(RAM_ROWS);
   localparam int FB_AW     = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1;
   localparam int CLR_ROWS  = (RAM_ROWS > FB_WORDS) ? RAM_ROWS : FB_WORDS;
   localparam int CLR_W     = $clog2(CLR_ROWS);

   localparam logic [31:0] RAM_LIMIT    = 32'(RAM_BYTES);
   localparam logic [31:0] RAM_LAST_WORD = 32'(RAM_BYTES - 4);

   // opcodes
   localparam logic [6:0] OP_LUI   = 7'h37;
   localparam logic [6:0] OP_IMM   = 7'h13;
   localparam logic [6:0] OP_REG   = 7'h33;
   localparam logic [6:0] OP_LOAD  = 7'h03;
   localparam logic [6:0] OP_STORE = 7'h23;
   localparam logic [6:0] OP_JALR  = 7'h67;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_W   = 3'd2;
   localparam logic [2:0] F3_B   = 3'd0;
   localparam logic [2:0] F3_BU  = 3'd4;
   localparam logic [6:0] F7_ADD = 7'd0;

   localparam logic [31:0] LUI_MASK = 32'hFFFF_F000;

   // result status codes
   localparam logic [1:0] ST_EXEC    = 2'd0;
   localparam logic [1:0] ST_LOADED  = 2'd1;
   localparam logic [1:0] ST_PCFAULT = 2'd2;
   localparam logic [1:0] ST_ILLEGAL = 2'd3;

   typedef struct packed {
      logic        is_step;
      logic        load_ok;
      logic [19:0] addr;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      logic             busy;
      logic [CLR_W-1:0] row;
   } clear_type;

endpackage
`default_nettype wire

// ===== design/rvc_front.sv =====
`default_nettype none
module rvc_front
   import rvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        clr_busy,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [19:0] req_load_addr,
   input  wire logic [7:0]  req_load_byte,
   output logic             q_valid,
   output item_type         q_item,
   input  wire logic        q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   new_item;

   always_comb begin
      new_item.is_step = req_func;
      new_item.load_ok = 32'(req_load_addr) < RAM_LIMIT;
      new_item.addr    = req_load_addr;
      new_item.data    = req_load_byte;
   end

   assign req_stall = (cnt_ff == 2'd2) || clr_busy;
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== design/rvc_back.sv =====
`default_nettype none
module rvc_back
   import rvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire clear_type   clr,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_pc_after,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_fb_written
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_MEM  = 3'd3;
   localparam logic [2:0] S_WB   = 3'd4;

   localparam logic [1:0] SRC_ZERO  = 2'd0;
   localparam logic [1:0] SRC_FB    = 2'd1;
   localparam logic [1:0] SRC_RAMW  = 2'd2;
   localparam logic [1:0] SRC_RAMB  = 2'd3;

   // storage
   logic [7:0]  ram_lane [4][RAM_ROWS];
   logic [31:0] fb_mem [FB_WORDS];
   logic [31:0] rf_mem [32];
   logic [31:0] rf_valid_ff;

   // control and state
   logic [2:0]  state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   logic [1:0]  halted_ff, halted_in;
   logic        dirty_ff, dirty_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [31:0] inst_ff, inst_in;
   logic [1:0]  ld_src_ff, ld_src_in;
   logic [1:0]  ld_off_ff, ld_off_in;
   logic [4:0]  ld_rd_ff, ld_rd_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_wr_ff, res_wr_in;
   logic [4:0]  res_idx_ff, res_idx_in;
   logic [31:0] res_val_ff, res_val_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_pc_ff, rsp_pc_in;
   logic        rsp_wr_ff, rsp_wr_in;
   logic [4:0]  rsp_idx_ff, rsp_idx_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic        rsp_dirty_ff, rsp_dirty_in;

   // memory ports
   logic [3:0]       lane_we;
   logic [ROW_W-1:0] lane_wa [4];
   logic [7:0]       lane_wd [4];
   logic [ROW_W-1:0] lane_ra [4];
   logic [7:0]       lane_q_ff [4];
   logic             fb_we;
   logic [FB_AW-1:0] fb_wa, fb_ra;
   logic [31:0]      fb_wd, fb_q_ff;
   logic             rf_we;
   logic [4:0]       rf_wa, rf_ra1, rf_ra2;
   logic [31:0]      rf_wd, rf_q1_ff, rf_q2_ff;
   logic             rf_v1_ff, rf_v2_ff;

   // decode
   logic [31:0] fetch_word;
   logic [6:0]  op, f7;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] immi, imms, opa, opb, ea, fb_off, pc_next;
   logic        ea_fb, ea_aligned, ea_in_b, ea_in_w;
   logic [ROW_W-1:0] ea_row;
   logic [1:0]  ea_off;
   logic [31:0] ld_word;
   logic        out_free;

   assign fetch_word = {lane_q_ff[3], lane_q_ff[2], lane_q_ff[1], lane_q_ff[0]};
   assign op   = inst_ff[6:0];
   assign rd   = inst_ff[11:7];
   assign f3   = inst_ff[14:12];
   assign f7   = inst_ff[31:25];
   assign immi = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign imms = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign opa  = rf_v1_ff ? rf_q1_ff : 32'd0;
   assign opb  = rf_v2_ff ? rf_q2_ff : 32'd0;
   assign ea   = opa + ((op == OP_STORE) ? imms : immi);
   assign fb_off     = ea - FB_BASE;
   assign ea_fb      = (ea >= FB_BASE) && (fb_off < FB_LIMIT);
   assign ea_aligned = ea[1:0] == 2'd0;
   assign ea_in_b    = ea < RAM_LIMIT;
   assign ea_in_w    = ea <= RAM_LAST_WORD;
   assign ea_row     = ea[ROW_W+1:2];
   assign ea_off     = ea[1:0];
   assign pc_next    = pc_ff + 32'd4;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // unaligned word: byte j comes from lane (off + j)
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         ld_word[8*j +: 8] = lane_q_ff[2'(2'(j) + ld_off_ff)];
      end
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      halted_in     = halted_ff;
      dirty_in      = dirty_ff;
      inst_in       = inst_ff;
      ld_src_in     = ld_src_ff;
      ld_off_in     = ld_off_ff;
      ld_rd_in      = ld_rd_ff;
      res_status_in = res_status_ff;
      res_wr_in     = res_wr_ff;
      res_idx_in    = res_idx_ff;
      res_val_in    = res_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_wr_in     = rsp_wr_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      q_pop         = 1'b0;
      lane_we       = 4'b0;
      fb_we         = 1'b0;
      fb_wa         = fb_off[FB_AW+1:2];
      fb_wd         = opb;
      fb_ra         = fb_off[FB_AW+1:2];
      rf_we         = 1'b0;
      rf_wa         = rd;
      rf_wd         = 32'd0;
      rf_ra1        = fetch_word[19:15];
      rf_ra2        = fetch_word[24:20];
      for (int k = 0; k < 4; k++) begin
         lane_wa[k] = ea_row;
         lane_wd[k] = 8'd0;
         lane_ra[k] = pc_ff[ROW_W+1:2];
      end

      if (clr.busy) begin
         for (int k = 0; k < 4; k++) begin
            lane_we[k] = 32'(clr.row) < 32'(RAM_ROWS);
            lane_wa[k] = clr.row[ROW_W-1:0];
         end
         fb_we = 32'(clr.row) < 32'(FB_WORDS);
         fb_wa = clr.row[FB_AW-1:0];
         fb_wd = '1;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid && !clr.busy) begin
               q_pop      = 1'b1;
               res_wr_in  = 1'b0;
               res_idx_in = 5'd0;
               res_val_in = 32'd0;
               state_in   = S_WB;
               if (!q_item.is_step) begin
                  res_status_in = ST_LOADED;
                  if (q_item.load_ok) begin
                     lane_we[q_item.addr[1:0]] = 1'b1;
                     for (int k = 0; k < 4; k++) begin
                        lane_wa[k] = q_item.addr[ROW_W+1:2];
                        lane_wd[k] = q_item.data;
                     end
                  end
               end else if (halted_ff != ST_EXEC) begin
                  res_status_in = halted_ff;
               end else if (pc_ff >= RAM_LIMIT || pc_ff[1:0] != 2'd0) begin
                  halted_in     = ST_PCFAULT;
                  res_status_in = ST_PCFAULT;
               end else begin
                  res_status_in = ST_EXEC;
                  state_in      = S_DEC;
               end
            end
         end
         S_DEC: begin
            inst_in  = fetch_word;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            pc_in    = pc_next;
            state_in = S_WB;
            rf_wd    = 32'd0;
            for (int k = 0; k < 4; k++) begin
               lane_ra[k] = (2'(k) < ea_off) ? ea_row + ROW_W'(1) : ea_row;
               lane_wa[k] = (2'(k) < ea_off) ? ea_row + ROW_W'(1) : ea_row;
               lane_wd[k] = opb[8*(2'(2'(k) - ea_off)) +: 8];
            end
            case (op)
               OP_LUI: begin
                  rf_we = 1'b1;
                  rf_wd = inst_ff & LUI_MASK;
               end
               OP_IMM: begin
                  rf_we = f3 == F3_ADD;
                  rf_wd = opa + immi;
               end
               OP_REG: begin
                  rf_we = (f3 == F3_ADD) && (f7 == F7_ADD);
                  rf_wd = opa + opb;
               end
               OP_LOAD: begin
                  if (f3 == F3_W || f3 == F3_BU) begin
                     pc_in     = pc_ff;
                     state_in  = S_MEM;
                     ld_off_in = ea_off;
                     ld_rd_in  = rd;
                     if (ea_fb) begin
                        ld_src_in = (f3 == F3_W && ea_aligned) ? SRC_FB : SRC_ZERO;
                     end else if (f3 == F3_W) begin
                        ld_src_in = ea_in_w ? SRC_RAMW : SRC_ZERO;
                     end else begin
                        ld_src_in = ea_in_b ? SRC_RAMB : SRC_ZERO;
                     end
                  end
               end
               OP_STORE: begin
                  if (ea_fb) begin
                     if (f3 == F3_W && ea_aligned) begin
                        fb_we    = 1'b1;
                        dirty_in = 1'b1;
                     end
                  end else if (f3 == F3_W && ea_in_w) begin
                     lane_we = 4'hF;
                  end else if (f3 == F3_B && ea_in_b) begin
                     lane_we[ea_off] = 1'b1;
                     lane_wd[ea_off] = opb[7:0];
                  end
               end
               OP_JALR: begin
                  rf_we = 1'b1;
                  rf_wd = pc_next;
                  pc_in = {ea[31:1], 1'b0};
               end
               default: begin
                  pc_in         = pc_ff;
                  halted_in     = ST_ILLEGAL;
                  res_status_in = ST_ILLEGAL;
               end
            endcase
            rf_we      = rf_we && (rd != 5'd0);
            res_wr_in  = rf_we;
            res_idx_in = rf_we ? rd : 5'd0;
            res_val_in = rf_we ? rf_wd : 32'd0;
         end
         S_MEM: begin
            pc_in    = pc_next;
            state_in = S_WB;
            case (ld_src_ff)
               SRC_FB:   rf_wd = fb_q_ff;
               SRC_RAMW: rf_wd = ld_word;
               SRC_RAMB: rf_wd = {24'd0, lane_q_ff[ld_off_ff]};
               default:  rf_wd = 32'd0;
            endcase
            rf_wa      = ld_rd_ff;
            rf_we      = ld_rd_ff != 5'd0;
            res_wr_in  = rf_we;
            res_idx_in = rf_we ? ld_rd_ff : 5'd0;
            res_val_in = rf_we ? rf_wd : 32'd0;
         end
         S_WB: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pc_in     = pc_ff;
               rsp_wr_in     = res_wr_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_val_in    = res_val_ff;
               rsp_dirty_in  = dirty_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 32'd0;
         halted_ff    <= ST_EXEC;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= 32'd0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we) begin
            rf_valid_ff[rf_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      inst_ff       <= inst_in;
      ld_src_ff     <= ld_src_in;
      ld_off_ff     <= ld_off_in;
      ld_rd_ff      <= ld_rd_in;
      res_status_ff <= res_status_in;
      res_wr_ff     <= res_wr_in;
      res_idx_ff    <= res_idx_in;
      res_val_ff    <= res_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_wr_ff     <= rsp_wr_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_dirty_ff  <= rsp_dirty_in;
   end

   // byte-lane RAM
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (lane_we[k]) begin
            ram_lane[k][lane_wa[k]] <= lane_wd[k];
         end
         lane_q_ff[k] <= ram_lane[k][lane_ra[k]];
      end
   end

   // framebuffer
   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_mem[fb_wa] <= fb_wd;
      end
      fb_q_ff <= fb_mem[fb_ra];
   end

   // register file
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      rf_q1_ff <= rf_mem[rf_ra1];
      rf_q2_ff <= rf_mem[rf_ra2];
      rf_v1_ff <= rf_valid_ff[rf_ra1];
      rf_v2_ff <= rf_valid_ff[rf_ra2];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pc_after     = rsp_pc_ff;
   assign rsp_reg_written  = rsp_wr_ff;
   assign rsp_reg_index    = rsp_idx_ff;
   assign rsp_reg_value    = rsp_val_ff;
   assign rsp_fb_written   = rsp_dirty_ff;

endmodule
`default_nettype wire

// ===== design/rv32_subset_core_with_fb_mmio.sv =====
// A program-byte load, or a step on a halted core or bad pc, goes from transfer in
//   through the back-end IDLE and WB states to the result register; a step runs fetch,
//   decode/reg read, execute, memory (LW/LBU only) and writeback states. The back-end
//   sequencer finishes one item before it takes the next; a 2-entry queue takes transfers.
// Reset: synchronous, active high. After reset a clearing pass over max(RAM_BYTES/4, FB_WORDS)
//   rows (262144 here) zeroes RAM and fills the framebuffer with ones; req_stall is high.
`default_nettype none
module rv32_subset_core_with_fb_mmio
   import rvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [19:0] req_load_addr,
   input  wire logic [7:0]  req_load_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_pc_after,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_fb_written
);

   // Post-reset clearing pass: one RAM row (4 bytes) and one framebuffer word per cycle.
   logic             clr_busy_ff, clr_busy_in;
   logic [CLR_W-1:0] clr_row_ff, clr_row_in;
   clear_type        clr;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         if (32'(clr_row_ff) == 32'(CLR_ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_row_in = clr_row_ff + CLR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   assign clr.busy = clr_busy_ff;
   assign clr.row  = clr_row_ff;

   // front end: takes transfers, tags loads vs. steps and in-range load addresses
   logic     q_valid, q_pop;
   item_type q_item;

   rvc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .clr_busy      (clr_busy_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_load_addr (req_load_addr),
      .req_load_byte (req_load_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // back end: executes one item at a time and owns RAM, framebuffer and register file;
   // its result register lets it execute the next item while rsp side stalls, waiting in WB
   rvc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .clr              (clr),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pc_after     (rsp_pc_after),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_fb_written   (rsp_fb_written)
   );

endmodule
`default_nettype wire

// ===== design/rvc_checker.sv =====
`default_nettype none
module rvc_checker
   import rvc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_reg_written,
   input wire logic [4:0]  rsp_reg_index,
   input wire logic        rsp_fb_written
);

   logic seen_dirty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_dirty_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_fb_written) begin
         seen_dirty_ff <= 1'b1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");

   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_dirty_ff |-> rsp_fb_written)
      else $error("framebuffer written flag cleared");

   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_written |-> rsp_reg_index != 5'd0)
      else $error("write to x0 reported");

   a_no_wr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_EXEC) |-> !rsp_reg_written)
      else $error("register write on load or halt");

endmodule

bind rv32_subset_core_with_fb_mmio rvc_checker u_rvc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_reg_written  (rsp_reg_written),
   .rsp_reg_index    (rsp_reg_index),
   .rsp_fb_written   (rsp_fb_written)
);
`default_nettype wire
